// ===== rtl/vip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vip_pkg;

	localparam int FRAC_BITS = 14;

	// operand and unit widths
	localparam int OPD_W  = 18;
	localparam int PROD_W = 2 * OPD_W;
	localparam int DEN_W  = 22;
	localparam int NUM_W  = 34;
	localparam int DMAG_W = DEN_W - 1;
	localparam int RAD_W  = 34;
	localparam int ROOT_W = RAD_W / 2;
	localparam int SREM_W = ROOT_W + 3;
	localparam int OUT_W  = 24;
	localparam int ITER_STAGES = NUM_W / 2;

	localparam logic signed [OPD_W-1:0] FIX_ONE  = OPD_W'(1 << FRAC_BITS);
	localparam logic signed [OPD_W-1:0] EVI_GAIN = OPD_W'(5 << FRAC_BITS);
	localparam logic signed [DEN_W-1:0] EVI_BIAS = DEN_W'(2 << FRAC_BITS);

	localparam logic [2:0] MODE_SAVI   = 3'd0;
	localparam logic [2:0] MODE_EVI    = 3'd1;
	localparam logic [2:0] MODE_MSAVI2 = 3'd2;
	localparam logic [2:0] MODE_GNDVI  = 3'd3;
	localparam logic [2:0] MODE_NDWI   = 3'd4;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_SOIL   = 2'd1;
	localparam logic [1:0] REG_ND_EN  = 2'd2;
	localparam logic [1:0] REG_ND_VAL = 2'd3;

	// per-word control that rides along the iteration pipeline
	typedef struct packed {
		logic                    nod;
		logic                    deg;
		logic                    dsign;
		logic [2:0]              mode;
		logic signed [OPD_W-1:0] inner;
		logic [OUT_W-1:0]        nod_val;
	} vip_side_t;

endpackage
`default_nettype wire

// ===== rtl/vip_divsqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vip_divsqrt (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 ready,
	input  wire vip_pkg::vip_side_t              in_side,
	input  wire logic [vip_pkg::NUM_W-1:0]       in_num,
	input  wire logic [vip_pkg::DMAG_W-1:0]      in_den,
	input  wire logic [vip_pkg::RAD_W-1:0]       in_rad,
	output logic                                 out_valid,
	input  wire logic                            out_adv,
	output vip_pkg::vip_side_t                   out_side,
	output logic [vip_pkg::NUM_W-1:0]            out_quo,
	output logic [vip_pkg::ROOT_W-1:0]           out_root
);

	localparam int N = vip_pkg::ITER_STAGES;

	logic                          v_s    [N];
	vip_pkg::vip_side_t            side_s [N];
	logic [vip_pkg::NUM_W-1:0]     num_s  [N];
	logic [vip_pkg::DMAG_W-1:0]    drem_s [N];
	logic [vip_pkg::DMAG_W-1:0]    den_s  [N];
	logic [vip_pkg::RAD_W-1:0]     rad_s  [N];
	logic [vip_pkg::SREM_W-1:0]    srem_s [N];
	logic [vip_pkg::ROOT_W-1:0]    root_s [N];
	logic [N:0]                    adv;

	// one restoring division step: shift in a numerator bit, subtract if it fits
	function automatic logic [vip_pkg::DMAG_W+vip_pkg::NUM_W-1:0] div_step(
		input logic [vip_pkg::DMAG_W-1:0] rem,
		input logic [vip_pkg::NUM_W-1:0]  num,
		input logic [vip_pkg::DMAG_W-1:0] den
	);
		logic [vip_pkg::DMAG_W:0]   t;
		logic                       ge;
		logic [vip_pkg::DMAG_W:0]   d;
		t  = {rem, num[vip_pkg::NUM_W-1]};
		ge = t >= {1'b0, den};
		d  = t - {1'b0, den};
		return {ge ? d[vip_pkg::DMAG_W-1:0] : t[vip_pkg::DMAG_W-1:0],
			num[vip_pkg::NUM_W-2:0], ge};
	endfunction

	// one digit of the bitwise square root
	function automatic logic [vip_pkg::SREM_W+vip_pkg::ROOT_W-1:0] sqrt_step(
		input logic [vip_pkg::SREM_W-1:0] rem,
		input logic [vip_pkg::ROOT_W-1:0] root,
		input logic [vip_pkg::RAD_W-1:0]  rad
	);
		logic [vip_pkg::SREM_W-1:0] t;
		logic [vip_pkg::SREM_W-1:0] trial;
		logic                       ge;
		t     = {rem[vip_pkg::SREM_W-3:0], rad[vip_pkg::RAD_W-1 -: 2]};
		trial = {1'b0, root, 2'b01};
		ge    = t >= trial;
		return {ge ? t - trial : t, root[vip_pkg::ROOT_W-2:0], ge};
	endfunction

	assign adv[N] = out_adv;
	assign ready  = adv[0];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                       pv;
		vip_pkg::vip_side_t         pside;
		logic [vip_pkg::NUM_W-1:0]  pnum;
		logic [vip_pkg::DMAG_W-1:0] prem;
		logic [vip_pkg::DMAG_W-1:0] pden;
		logic [vip_pkg::RAD_W-1:0]  prad;
		logic [vip_pkg::SREM_W-1:0] psrem;
		logic [vip_pkg::ROOT_W-1:0] proot;
		logic [vip_pkg::DMAG_W+vip_pkg::NUM_W-1:0] d1, d2;
		logic [vip_pkg::SREM_W+vip_pkg::ROOT_W-1:0] sq;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign pside = in_side;
			assign pnum  = in_num;
			assign prem  = '0;
			assign pden  = in_den;
			assign prad  = in_rad;
			assign psrem = '0;
			assign proot = '0;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign pside = side_s[k-1];
			assign pnum  = num_s[k-1];
			assign prem  = drem_s[k-1];
			assign pden  = den_s[k-1];
			assign prad  = rad_s[k-1];
			assign psrem = srem_s[k-1];
			assign proot = root_s[k-1];
		end

		assign d1 = div_step(prem, pnum, pden);
		assign d2 = div_step(d1[vip_pkg::DMAG_W+vip_pkg::NUM_W-1 -: vip_pkg::DMAG_W],
			d1[vip_pkg::NUM_W-1:0], pden);
		assign sq = sqrt_step(psrem, proot, prad);

		// a stage takes new data when empty or when the next one moves
		assign adv[k] = !v_s[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv[k]) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				side_s[k] <= pside;
				num_s[k]  <= d2[vip_pkg::NUM_W-1:0];
				drem_s[k] <= d2[vip_pkg::DMAG_W+vip_pkg::NUM_W-1 -: vip_pkg::DMAG_W];
				den_s[k]  <= pden;
				rad_s[k]  <= {prad[vip_pkg::RAD_W-3:0], 2'b00};
				srem_s[k] <= sq[vip_pkg::SREM_W+vip_pkg::ROOT_W-1 -: vip_pkg::SREM_W];
				root_s[k] <= sq[vip_pkg::ROOT_W-1:0];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_side  = side_s[N-1];
	assign out_quo   = num_s[N-1];
	assign out_root  = root_s[N-1];

endmodule
`default_nettype wire

// ===== rtl/vegetation_index_pixel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Per-pixel vegetation index: SAVI, EVI, MSAVI2, GNDVI or NDWI.
// Input channel: in_valid / in_stall with the four Q2.14 reflectances; a word
// moves on a rising edge with valid high and stall low. Output channel:
// out_valid / out_stall with the Q10.14 index and its three flags.
// Configuration: write cfg_data into register cfg_index while cfg_we is high
// (0 mode, 1 soil factor, 2 no-data enable, 3 no-data code); write only
// while no pixel is in flight.
// Pipeline: 21 register stages (three setup stages, 17 iteration stages, one
// output register). Throughput: one pixel a cycle while out_stall is low;
// the 17-stage divider/root array retires two quotient bits and one root
// bit per stage, and every stage holds one pixel.
// Reset clears all valid bits and loads the register defaults (mode SAVI,
// L = 0.5, no-data off, code 0).
// When the receiver stalls, the output register holds its word; stages
// behind it keep filling bubbles and in_stall rises only once the pipe
// is full up to the input.
module vegetation_index_pixel (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] nir_sample,
	input  wire logic signed [15:0] red_sample,
	input  wire logic signed [15:0] blue_sample,
	input  wire logic signed [15:0] green_sample,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      index_value,
	output logic                    is_nodata,
	output logic                    degenerate,
	output logic                    saturated,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	localparam int OPD_W  = vip_pkg::OPD_W;
	localparam int DEN_W  = vip_pkg::DEN_W;
	localparam int PROD_W = vip_pkg::PROD_W;
	localparam int OUT_W  = vip_pkg::OUT_W;
	localparam int DISC_W = PROD_W + 1;

	// configuration registers
	logic [2:0]  mode_q;
	logic [14:0] soil_q;
	logic        nd_en_q;
	logic [15:0] nd_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= vip_pkg::MODE_SAVI;
			soil_q    <= 15'd8192;
			nd_en_q   <= 1'b0;
			nd_code_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vip_pkg::REG_MODE:   mode_q    <= cfg_data[2:0];
				vip_pkg::REG_SOIL:   soil_q    <= cfg_data[14:0];
				vip_pkg::REG_ND_EN:  nd_en_q   <= cfg_data[0];
				vip_pkg::REG_ND_VAL: nd_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage advance; the output register releases when empty or taken
	logic adv_out, adv3, adv2, adv1, it_ready;
	logic v1_s1, v2_s2, v3_s3;

	assign adv_out  = !out_valid || !out_stall;
	assign adv3     = !v3_s3 || it_ready;
	assign adv2     = !v2_s2 || adv3;
	assign adv1     = !v1_s1 || adv2;
	assign in_stall = !adv1;

	// ---- stage 1: pick multiplier operands and denominator per mode ----
	logic signed [OPD_W-1:0] n18, r18, g18, inner, dnr;
	logic signed [DEN_W-1:0] n22, r22, b22, g22;
	logic signed [OPD_W-1:0] mul_a, mul_b;
	logic signed [DEN_W-1:0] den;
	logic                    nod;

	assign n18   = {{(OPD_W-16){nir_sample[15]}}, nir_sample};
	assign r18   = {{(OPD_W-16){red_sample[15]}}, red_sample};
	assign g18   = {{(OPD_W-16){green_sample[15]}}, green_sample};
	assign n22   = {{(DEN_W-16){nir_sample[15]}}, nir_sample};
	assign r22   = {{(DEN_W-16){red_sample[15]}}, red_sample};
	assign b22   = {{(DEN_W-16){blue_sample[15]}}, blue_sample};
	assign g22   = {{(DEN_W-16){green_sample[15]}}, green_sample};
	assign dnr   = n18 - r18;
	assign inner = (n18 <<< 1) + vip_pkg::FIX_ONE;
	assign nod   = nd_en_q && (nir_sample == nd_code_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		den   = '0;
		unique case (mode_q)
			vip_pkg::MODE_SAVI: begin
				mul_a = dnr;
				mul_b = vip_pkg::FIX_ONE + {{(OPD_W-15){1'b0}}, soil_q};
				den   = n22 + r22 + {{(DEN_W-15){1'b0}}, soil_q};
			end
			vip_pkg::MODE_EVI: begin
				// denominator doubled so the 7.5 blue term stays integral
				mul_a = dnr;
				mul_b = vip_pkg::EVI_GAIN;
				den   = (n22 <<< 1) + (r22 <<< 3) + (r22 <<< 2) - (b22 <<< 4) + b22
					+ vip_pkg::EVI_BIAS;
			end
			vip_pkg::MODE_MSAVI2: begin
				mul_a = inner;
				mul_b = inner;
			end
			vip_pkg::MODE_GNDVI: begin
				mul_a = n18 - g18;
				mul_b = vip_pkg::FIX_ONE;
				den   = n22 + g22;
			end
			vip_pkg::MODE_NDWI: begin
				mul_a = g18 - n18;
				mul_b = vip_pkg::FIX_ONE;
				den   = g22 + n22;
			end
			default: ;
		endcase
	end

	logic [2:0]              mode_s1;
	logic                    nod_s1;
	logic [OUT_W-1:0]        nodv_s1;
	logic signed [OPD_W-1:0] mul_a_s1, mul_b_s1, dnr_s1, inner_s1;
	logic signed [DEN_W-1:0] den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (adv1) begin
			v1_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			mode_s1  <= mode_q;
			nod_s1   <= nod;
			nodv_s1  <= {{(OUT_W-16){nd_code_q[15]}}, nd_code_q};
			mul_a_s1 <= mul_a;
			mul_b_s1 <= mul_b;
			dnr_s1   <= dnr;
			inner_s1 <= inner;
			den_s1   <= den;
		end
	end

	// ---- stage 2: the one multiply ----
	logic [2:0]               mode_s2;
	logic                     nod_s2;
	logic [OUT_W-1:0]         nodv_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [OPD_W-1:0]  dnr_s2, inner_s2;
	logic signed [DEN_W-1:0]  den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (adv2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			mode_s2  <= mode_s1;
			nod_s2   <= nod_s1;
			nodv_s2  <= nodv_s1;
			prod_s2  <= mul_a_s1 * mul_b_s1;
			dnr_s2   <= dnr_s1;
			inner_s2 <= inner_s1;
			den_s2   <= den_s1;
		end
	end

	// ---- stage 3: magnitudes, signs, discriminant, degenerate flag ----
	logic signed [DISC_W-1:0] disc;
	logic signed [DISC_W-1:0] dnr_x;
	logic [PROD_W-1:0]        prod_mag;
	logic [DEN_W-1:0]         den_mag;
	logic                     deg;

	assign dnr_x    = {{(DISC_W-OPD_W){dnr_s2[OPD_W-1]}}, dnr_s2};
	assign disc     = {prod_s2[PROD_W-1], prod_s2} - (dnr_x <<< (vip_pkg::FRAC_BITS + 3));
	assign prod_mag = prod_s2[PROD_W-1] ? PROD_W'(-prod_s2) : PROD_W'(prod_s2);
	assign den_mag  = den_s2[DEN_W-1] ? DEN_W'(-den_s2) : DEN_W'(den_s2);

	always_comb begin
		case (mode_s2) inside
			vip_pkg::MODE_MSAVI2: deg = disc[DISC_W-1];
			vip_pkg::MODE_SAVI, vip_pkg::MODE_EVI, vip_pkg::MODE_GNDVI,
			vip_pkg::MODE_NDWI:   deg = (den_s2 == '0);
			default:              deg = 1'b0;
		endcase
	end

	vip_pkg::vip_side_t          side_s3;
	logic [vip_pkg::NUM_W-1:0]   num_s3;
	logic [vip_pkg::DMAG_W-1:0]  dmag_s3;
	logic [vip_pkg::RAD_W-1:0]   rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (adv3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			side_s3.nod     <= nod_s2;
			side_s3.deg     <= deg;
			side_s3.dsign   <= prod_s2[PROD_W-1] ^ den_s2[DEN_W-1];
			side_s3.mode    <= mode_s2;
			side_s3.inner   <= inner_s2;
			side_s3.nod_val <= nodv_s2;
			num_s3          <= prod_mag[vip_pkg::NUM_W-1:0];
			dmag_s3         <= den_mag[vip_pkg::DMAG_W-1:0];
			rad_s3          <= disc[vip_pkg::RAD_W-1:0];
		end
	end

	// ---- iteration array: divider and square root side by side ----
	logic                         it_valid;
	vip_pkg::vip_side_t           it_side;
	logic [vip_pkg::NUM_W-1:0]    it_quo;
	logic [vip_pkg::ROOT_W-1:0]   it_root;

	vip_divsqrt u_divsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v3_s3),
		.ready     (it_ready),
		.in_side   (side_s3),
		.in_num    (num_s3),
		.in_den    (dmag_s3),
		.in_rad    (rad_s3),
		.out_valid (it_valid),
		.out_adv   (adv_out),
		.out_side  (it_side),
		.out_quo   (it_quo),
		.out_root  (it_root)
	);

	// ---- output stage: sign, clip, select ----
	localparam logic [vip_pkg::NUM_W-1:0] POS_LIM = vip_pkg::NUM_W'((1 << (OUT_W-1)) - 1);
	localparam logic [vip_pkg::NUM_W-1:0] NEG_LIM = vip_pkg::NUM_W'(1 << (OUT_W-1));
	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	logic signed [OPD_W:0] ms_diff;
	logic signed [OPD_W:0] ms_half;
	logic [OUT_W-1:0]      res_val;
	logic                  res_sat;

	// truncate toward zero: bump odd negatives before the shift
	assign ms_diff = {it_side.inner[OPD_W-1], it_side.inner}
		- {{(OPD_W+1-vip_pkg::ROOT_W){1'b0}}, it_root};
	assign ms_half = (ms_diff + $signed({{OPD_W{1'b0}}, ms_diff[OPD_W] & ms_diff[0]})) >>> 1;

	always_comb begin
		res_val = '0;
		res_sat = 1'b0;
		if (it_side.nod) begin
			res_val = it_side.nod_val;
		end else if (it_side.deg) begin
			res_val = '0;
		end else begin
			case (it_side.mode) inside
				vip_pkg::MODE_MSAVI2: begin
					res_val = {{(OUT_W-OPD_W-1){ms_half[OPD_W]}}, ms_half};
				end
				vip_pkg::MODE_SAVI, vip_pkg::MODE_EVI, vip_pkg::MODE_GNDVI,
				vip_pkg::MODE_NDWI: begin
					if (!it_side.dsign) begin
						res_sat = it_quo > POS_LIM;
						res_val = res_sat ? OUT_MAX : it_quo[OUT_W-1:0];
					end else begin
						res_sat = it_quo > NEG_LIM;
						res_val = res_sat ? OUT_MIN : OUT_W'(-it_quo[OUT_W-1:0]);
					end
				end
				default: ;
			endcase
		end
	end

	logic [OUT_W-1:0] val_q;
	logic             nod_q, deg_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_out) begin
			out_valid <= it_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			val_q <= res_val;
			nod_q <= it_side.nod;
			deg_q <= it_side.deg && !it_side.nod;
			sat_q <= res_sat;
		end
	end

	assign index_value = val_q;
	assign is_nodata   = nod_q;
	assign degenerate  = deg_q;
	assign saturated   = sat_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_vegetation_index_pixel.sv =====
`timescale 1ns / 1ps
module tb_vegetation_index_pixel;

	// the block leaves modes 5..7 without a formula
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam logic [2:0] M_SAVI   = vip_pkg::MODE_SAVI;
	localparam logic [2:0] M_EVI    = vip_pkg::MODE_EVI;
	localparam logic [2:0] M_MSAVI2 = vip_pkg::MODE_MSAVI2;
	localparam logic [2:0] M_GNDVI  = vip_pkg::MODE_GNDVI;
	localparam logic [2:0] M_NDWI   = vip_pkg::MODE_NDWI;
	localparam int DRAIN_CYCLES = 30;
	localparam int STALL_LIMIT  = 5000;   // cycles without any word moving
	localparam int ITEMS_PER_PHASE = 190;

	localparam logic signed [23:0] IDX_MAX = 24'sd8388607;
	localparam logic signed [23:0] IDX_MIN = -24'sd8388608;

	typedef struct {
		logic signed [23:0] value;
		logic               nod;
		logic               deg;
		logic               sat;
	} index_word_t;

	typedef struct {
		logic [2:0]         mode;
		logic [15:0]        soil;
		logic               nd_en;
		logic signed [15:0] nd_code;
		logic signed [15:0] n, r, b, g;
		bit                 typed;
		index_word_t        want;
	} pixel_row_t;

	logic               clk, arst_n;
	logic               in_valid, in_stall;
	logic signed [15:0] nir_sample, red_sample, blue_sample, green_sample;
	logic               out_valid, out_stall;
	logic signed [23:0] index_value;
	logic               is_nodata, degenerate, saturated;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	vegetation_index_pixel DUT (.*);

	// shadow copy of the register file
	logic [2:0]         sh_mode;
	logic [14:0]        sh_soil;
	logic               sh_nd_en;
	logic signed [15:0] sh_nd_code;

	index_word_t pending_index_q[$];
	int          fail_count = 0;
	int          pace_mode  = 0;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both light
	int          quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// compute the expected index word from the shadow registers
	function automatic index_word_t predict_index(logic signed [15:0] n16, r16, b16, g16);
		index_word_t w;
		longint n, r, b, g, one, num, den, val, inner, disc;
		n = n16; r = r16; b = b16; g = g16;
		one = longint'(1) << vip_pkg::FRAC_BITS;
		val = 0;
		w = '{value: '0, nod: 1'b0, deg: 1'b0, sat: 1'b0};
		if (sh_nd_en && n16 == sh_nd_code) begin
			w.value = 24'(longint'(sh_nd_code));
			w.nod   = 1'b1;
			return w;
		end
		case (sh_mode)
			M_SAVI: begin
				num = (n - r) * (one + longint'(sh_soil));
				den = n + r + longint'(sh_soil);
				if (den == 0) w.deg = 1'b1; else val = num / den;
			end
			M_EVI: begin
				num = 5 * (n - r) * one;
				den = 2 * n + 12 * r - 15 * b + 2 * one;
				if (den == 0) w.deg = 1'b1; else val = num / den;
			end
			M_MSAVI2: begin
				inner = 2 * n + one;
				disc  = inner * inner - 8 * (n - r) * one;
				if (disc < 0) w.deg = 1'b1;
				else val = (inner - longint'(floor_sqrt(disc))) / 2;
			end
			M_GNDVI, M_NDWI: begin
				num = (sh_mode == M_GNDVI) ? (n - g) * one : (g - n) * one;
				den = n + g;
				if (den == 0) w.deg = 1'b1; else val = num / den;
			end
			default: val = 0;
		endcase
		if (val > longint'(IDX_MAX)) begin
			val = IDX_MAX;
			w.sat = 1'b1;
		end
		if (val < longint'(IDX_MIN)) begin
			val = IDX_MIN;
			w.sat = 1'b1;
		end
		w.value = 24'(val);
		return w;
	endfunction

	function automatic bit sender_idles();
		case (pace_mode)
			1: return $urandom_range(99) < 54;
			3: return $urandom_range(99) < 7;
			default: return 1'b0;
		endcase
	endfunction

	// receiver back-pressure, re-rolled every falling edge
	always @(negedge clk) begin
		case (pace_mode)
			2: out_stall <= $urandom_range(99) < 54;
			3: out_stall <= $urandom_range(99) < 7;
			default: out_stall <= 1'b0;
		endcase
	end

	// drain the pipe, then rewrite all four registers
	task automatic load_regs(logic [2:0] mode, logic [15:0] soil, logic nd_en,
			logic signed [15:0] code);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_index_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1; cfg_index <= vip_pkg::REG_MODE; cfg_data <= 16'(mode);
		@(negedge clk);
		cfg_index <= vip_pkg::REG_SOIL;   cfg_data <= soil;
		@(negedge clk);
		cfg_index <= vip_pkg::REG_ND_EN;  cfg_data <= 16'(nd_en);
		@(negedge clk);
		cfg_index <= vip_pkg::REG_ND_VAL; cfg_data <= code;
		@(negedge clk);
		cfg_we <= 1'b0;
		sh_mode = mode; sh_soil = soil[14:0]; sh_nd_en = nd_en; sh_nd_code = code;
	endtask

	// offer one pixel word, hold it until taken, queue its expected index
	task automatic send_pixel(logic signed [15:0] n, r, b, g, bit typed, index_word_t want);
		@(negedge clk);
		while (sender_idles()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		nir_sample <= n; red_sample <= r; blue_sample <= b; green_sample <= g;
		do @(posedge clk); while (in_stall);
		pending_index_q.push_back(typed ? want : predict_index(n, r, b, g));
	endtask

	// compare every word that leaves the block
	always @(posedge clk) begin
		index_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_index_q.size() == 0) begin
				$error("index word with nothing expected");
				fail_count++;
			end else begin
				w = pending_index_q.pop_front();
				if (index_value !== w.value) begin
					$error("index_value: expected %0d, got %0d", w.value, index_value);
					fail_count++;
				end
				if (is_nodata !== w.nod) begin
					$error("is_nodata: expected %0b, got %0b", w.nod, is_nodata);
					fail_count++;
				end
				if (degenerate !== w.deg) begin
					$error("degenerate: expected %0b, got %0b", w.deg, degenerate);
					fail_count++;
				end
				if (saturated !== w.sat) begin
					$error("saturated: expected %0b, got %0b", w.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	// watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	localparam index_word_t ZERO_W = '{value: 24'sd0, nod: 1'b0, deg: 1'b0, sat: 1'b0};
	localparam index_word_t DEG_W  = '{value: 24'sd0, nod: 1'b0, deg: 1'b1, sat: 1'b0};
	localparam index_word_t HI_W   = '{value: IDX_MAX, nod: 1'b0, deg: 1'b0, sat: 1'b1};
	localparam index_word_t LO_W   = '{value: IDX_MIN, nod: 1'b0, deg: 1'b0, sat: 1'b1};

	// directed rows: registers, pixel, and a typed answer where it is obvious
	pixel_row_t dir_rows[] = '{
		'{M_SAVI, 16'd8192, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, ZERO_W},
		'{M_SAVI, 16'd8192, 1'b0, 16'sd0, 16'sd12000, 16'sd3000, 16'sd900, 16'sd2000,
			1'b0, ZERO_W},
		'{M_SAVI, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd7, 1'b1, DEG_W},
		'{M_SAVI, 16'd0, 1'b0, 16'sd0, 16'sd32767, -16'sd32766, 16'sd0, 16'sd0, 1'b1, HI_W},
		'{M_SAVI, 16'd16384, 1'b0, 16'sd0, 16'sd32767, 16'sd32767, -16'sd32768,
			16'sd0, 1'b0, ZERO_W},
		'{M_SAVI, 16'hFFFF, 1'b0, 16'sd0, -16'sd32768, 16'sd32767, 16'sd1, 16'sd1,
			1'b0, ZERO_W},
		'{M_EVI, 16'd8192, 1'b0, 16'sd0, 16'sd10000, 16'sd2000, 16'sd1000, 16'sd0,
			1'b0, ZERO_W},
		'{M_EVI, 16'd8192, 1'b0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd1,
			1'b0, ZERO_W},
		'{M_EVI, 16'd8192, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd4369, 16'sd0, 1'b0, ZERO_W},
		'{M_MSAVI2, 16'd8192, 1'b0, 16'sd0, 16'sd12000, 16'sd3000, 16'sd0, 16'sd0,
			1'b0, ZERO_W},
		'{M_MSAVI2, 16'd8192, 1'b0, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0,
			1'b1, DEG_W},
		'{M_MSAVI2, 16'd8192, 1'b0, 16'sd0, -16'sd32768, 16'sd32767, -16'sd1, -16'sd1,
			1'b0, ZERO_W},
		'{M_GNDVI, 16'd8192, 1'b0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, -16'sd32766,
			1'b1, HI_W},
		'{M_GNDVI, 16'd8192, 1'b0, 16'sd0, -16'sd32766, 16'sd0, 16'sd0, 16'sd32767,
			1'b1, LO_W},
		'{M_GNDVI, 16'd8192, 1'b0, 16'sd0, 16'sd500, 16'sd9, 16'sd9, -16'sd500,
			1'b1, DEG_W},
		'{M_NDWI, 16'd8192, 1'b0, 16'sd0, 16'sd3000, 16'sd0, 16'sd0, 16'sd9000,
			1'b0, ZERO_W},
		'{M_NDWI, 16'd8192, 1'b0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767,
			1'b0, ZERO_W},
		'{MODE_SPARE_LO, 16'd8192, 1'b0, 16'sd0, 16'sd12000, 16'sd3, 16'sd4, 16'sd5,
			1'b1, ZERO_W},
		'{MODE_SPARE_HI, 16'd8192, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
			1'b1, ZERO_W},
		'{M_SAVI, 16'd8192, 1'b1, -16'sd32768, -16'sd32768, 16'sd5, 16'sd6, 16'sd7, 1'b1,
			'{value: -24'sd32768, nod: 1'b1, deg: 1'b0, sat: 1'b0}},
		'{M_SAVI, 16'd8192, 1'b1, -16'sd32768, -16'sd32767, 16'sd5, 16'sd6, 16'sd7,
			1'b0, ZERO_W},
		'{M_GNDVI, 16'd0, 1'b1, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0, -16'sd32767, 1'b1,
			'{value: 24'sd32767, nod: 1'b1, deg: 1'b0, sat: 1'b0}}
	};

	// phase settings for the random part: extremes and every mode
	pixel_row_t phase_regs[] = '{
		'{M_SAVI, 16'd8192, 1'b0, 16'sd0, 0, 0, 0, 0, 1'b0, ZERO_W},
		'{M_EVI, 16'd0, 1'b1, -16'sd32768, 0, 0, 0, 0, 1'b0, ZERO_W},
		'{M_MSAVI2, 16'd16384, 1'b1, 16'sd0, 0, 0, 0, 0, 1'b0, ZERO_W},
		'{M_GNDVI, 16'd1, 1'b0, 16'sd32767, 0, 0, 0, 0, 1'b0, ZERO_W},
		'{M_NDWI, 16'd4096, 1'b1, 16'sd8000, 0, 0, 0, 0, 1'b0, ZERO_W},
		'{M_SAVI, 16'hFFFF, 1'b1, 16'sd32767, 0, 0, 0, 0, 1'b0, ZERO_W},
		'{M_SAVI, 16'd0, 1'b0, 16'sd0, 0, 0, 0, 0, 1'b0, ZERO_W},
		'{MODE_SPARE_LO, 16'd8192, 1'b1, 16'sd100, 0, 0, 0, 0, 1'b0, ZERO_W},
		'{M_EVI, 16'd12000, 1'b0, 16'sd0, 0, 0, 0, 0, 1'b0, ZERO_W}
	};

	function automatic logic signed [15:0] pick_sample(int kind);
		case (kind)
			0: return 16'($urandom_range(16384));
			1: return 16'($urandom);
			default: begin
				case ($urandom_range(4))
					0: return -16'sd32768;
					1: return -16'sd1;
					2: return 16'sd0;
					3: return 16'sd1;
					default: return 16'sd32767;
				endcase
			end
		endcase
	endfunction

	initial begin
		logic signed [15:0] n, r, b, g;
		int kind;
		arst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0; cfg_we = 1'b0;
		cfg_index = vip_pkg::REG_MODE; cfg_data = '0;
		nir_sample = '0; red_sample = '0; blue_sample = '0; green_sample = '0;
		sh_mode = M_SAVI; sh_soil = 15'd8192; sh_nd_en = 1'b0; sh_nd_code = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows; the first runs on the reset values
		foreach (dir_rows[i]) begin
			if (i > 0 && (dir_rows[i].mode != sh_mode || dir_rows[i].soil[14:0] != sh_soil
					|| dir_rows[i].nd_en != sh_nd_en || dir_rows[i].nd_code != sh_nd_code))
				load_regs(dir_rows[i].mode, dir_rows[i].soil, dir_rows[i].nd_en,
					dir_rows[i].nd_code);
			send_pixel(dir_rows[i].n, dir_rows[i].r, dir_rows[i].b, dir_rows[i].g,
				dir_rows[i].typed, dir_rows[i].want);
		end

		// random phases; rotate pacing so gaps land on every pipe state
		foreach (phase_regs[p]) begin
			load_regs(phase_regs[p].mode, phase_regs[p].soil, phase_regs[p].nd_en,
				phase_regs[p].nd_code);
			pace_mode = p % 4;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				kind = $urandom_range(9);
				n = pick_sample(kind < 6 ? 0 : (kind < 8 ? 1 : 2));
				r = pick_sample(kind < 6 ? 0 : (kind < 8 ? 1 : 2));
				b = pick_sample(kind < 5 ? 0 : 1);
				g = pick_sample(kind < 6 ? 0 : (kind < 8 ? 1 : 2));
				if (kind == 6) begin
					// force a zero denominator in SAVI, GNDVI and NDWI modes
					g = -n;
					r = 16'(-longint'(n) - longint'(sh_soil));
				end
				if (kind == 7 && sh_nd_en) n = sh_nd_code;
				send_pixel(n, r, b, g, 1'b0, ZERO_W);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_index_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
